>>> sv/orm_pkg.sv
package orm_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_SOON = 2'd1;
  localparam status_t ST_WRAP = 2'd2;

  localparam int unsigned CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_OVER_SPEED = 3'd0;
  localparam cfg_idx_t CFG_BRAKE      = 3'd1;
  localparam cfg_idx_t CFG_ODO_EN     = 3'd2;
  localparam cfg_idx_t CFG_GPS_EN     = 3'd3;
  localparam cfg_idx_t CFG_TIMEOUT    = 3'd4;

  localparam logic [5:0] EV_MOVE  = 6'h01;
  localparam logic [5:0] EV_STOP  = 6'h02;
  localparam logic [5:0] EV_OVER  = 6'h04;
  localparam logic [5:0] EV_SAFE  = 6'h08;
  localparam logic [5:0] EV_BRAKE = 6'h10;

  localparam logic [1:0] FIX_GAIN = 2'h1;
  localparam logic [1:0] FIX_LOSS = 2'h2;

  localparam logic [5:0]  ODO_EN_RST  = 6'h3F;
  localparam logic [1:0]  GPS_EN_RST  = 2'h3;
  localparam logic [31:0] TIMEOUT_RST = 32'd30000;

  localparam logic [9:0] MS_PER_S = 10'd1000;

endpackage

>>> sv/odometer_rate_alarm_monitor_core.sv
// odometer rate and alarm monitor
// input channel: one word per poll (time_ms_i, pulse_count_i, gps_fix_i), taken when
// in_valid_i is high and in_stall_o is low. in_stall_o stays high from the accept until
// the result word has been taken, so one poll is worked at a time.
// output channel: one result word per poll, held on the ports while out_valid_o is high
// and out_stall_i is high; it is taken when out_stall_i is low.
// config channel: cfg_ready_o is always high; write only while no poll is in flight.
// a poll that comes too soon or after a time wrap goes from the check step straight
// to the output. a checked update may use the shared x1000 multiplier and the shared
// restoring divider, one quotient bit per cycle: 16 bits for the pulse frequency and
// 24 bits for the deceleration rate.
// a new poll is taken only once the result word is taken and the block is back in idle.
// reset: all tracking state and pending masks clear, enables go to all ones, the
// timeout to 30000 ms. a stalled receiver simply holds the block in its output state.
module odometer_rate_alarm_monitor_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [31:0]            time_ms_i,
  input  logic [31:0]            pulse_count_i,
  input  logic [1:0]             gps_fix_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output orm_pkg::status_t       status_o,
  output logic [15:0]            frequency_o,
  output logic signed [16:0]     frequency_change_o,
  output logic [5:0]             odo_pending_mask_o,
  output logic [1:0]             gps_pending_mask_o,
  output logic                   irq_request_o,
  output logic                   moving_flag_o,
  output logic                   pending_flag_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  orm_pkg::cfg_idx_t      cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import orm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_FLOAD = 4'd2;
  localparam logic [3:0] S_FDIV  = 4'd3;
  localparam logic [3:0] S_DF    = 4'd4;
  localparam logic [3:0] S_BLOAD = 4'd5;
  localparam logic [3:0] S_BDIV  = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]  state_q, state_d;

  // configuration
  logic [15:0] osl_q, osl_d;
  logic [23:0] brake_lim_q, brake_lim_d;
  logic [5:0]  odo_en_q, odo_en_d;
  logic [1:0]  gps_en_q, gps_en_d;
  logic [31:0] timeout_q, timeout_d;

  // tracking state
  logic [31:0] last_upd_q, last_upd_d;
  logic [31:0] prev_time_q, prev_time_d;
  logic [31:0] prev_count_q, prev_count_d;
  logic [15:0] prev_freq_q, prev_freq_d;
  logic [31:0] last_int_q, last_int_d;
  logic [15:0] checked_q, checked_d;
  logic [1:0]  last_fix_q, last_fix_d;
  logic [5:0]  odo_susp_q, odo_susp_d;
  logic [5:0]  odo_pend_q, odo_pend_d;
  logic [1:0]  gps_pend_q, gps_pend_d;
  logic [31:0] release_q, release_d;
  logic        irq_q, irq_d;
  logic        moving_q, moving_d;

  // working registers
  logic [31:0]        t1_q, t1_d;
  logic [31:0]        c1_q, c1_d;
  logic [1:0]         fix_q, fix_d;
  logic [41:0]        mul_q, mul_d;
  logic [31:0]        rem_q, rem_d;
  logic [23:0]        dv_q, dv_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [15:0]        freq_q, freq_d;
  logic signed [16:0] df_q, df_d;
  logic               brake_hit_q, brake_hit_d;

  // result word
  status_t            o_status_q, o_status_d;
  logic [15:0]        o_freq_q, o_freq_d;
  logic signed [16:0] o_df_q, o_df_d;
  logic [5:0]         o_odo_q, o_odo_d;
  logic [1:0]         o_gps_q, o_gps_d;
  logic               o_irq_q, o_irq_d;
  logic               o_mov_q, o_mov_d;
  logic               o_pflag_q, o_pflag_d;

  // shared multiplier and divider step
  logic [31:0] mul_a;
  logic [41:0] prod;
  logic [32:0] div_sh;
  logic [32:0] div_diff;
  logic        div_ge;
  logic [31:0] step_rem;
  logic [23:0] step_dv;

  assign prod     = 42'(mul_a) * 42'(MS_PER_S);
  assign div_sh   = {rem_q, dv_q[23]};
  assign div_ge   = div_sh >= {1'b0, last_int_q};
  assign div_diff = div_sh - {1'b0, last_int_q};
  assign step_rem = div_ge ? div_diff[31:0] : div_sh[31:0];
  assign step_dv  = {dv_q[22:0], div_ge};

  always_comb begin
    logic [31:0] dt;
    status_t     st;
    logic [16:0] df_mag;
    logic [5:0]  ev_odo;
    logic [1:0]  ev_gps;
    logic [5:0]  supp;
    logic [5:0]  hit;
    logic [5:0]  oth;
    logic        mov;
    logic        fire;
    logic [5:0]  odo_p;
    logic [1:0]  gps_p;
    logic        irq;
    logic [31:0] rel;
    logic        pflag;

    state_d      = state_q;
    osl_d        = osl_q;
    brake_lim_d  = brake_lim_q;
    odo_en_d     = odo_en_q;
    gps_en_d     = gps_en_q;
    timeout_d    = timeout_q;
    last_upd_d   = last_upd_q;
    prev_time_d  = prev_time_q;
    prev_count_d = prev_count_q;
    prev_freq_d  = prev_freq_q;
    last_int_d   = last_int_q;
    checked_d    = checked_q;
    last_fix_d   = last_fix_q;
    odo_susp_d   = odo_susp_q;
    odo_pend_d   = odo_pend_q;
    gps_pend_d   = gps_pend_q;
    release_d    = release_q;
    irq_d        = irq_q;
    moving_d     = moving_q;
    t1_d         = t1_q;
    c1_d         = c1_q;
    fix_d        = fix_q;
    mul_d        = mul_q;
    rem_d        = rem_q;
    dv_d         = dv_q;
    cnt_d        = cnt_q;
    freq_d       = freq_q;
    df_d         = df_q;
    brake_hit_d  = brake_hit_q;
    o_status_d   = o_status_q;
    o_freq_d     = o_freq_q;
    o_df_d       = o_df_q;
    o_odo_d      = o_odo_q;
    o_gps_d      = o_gps_q;
    o_irq_d      = o_irq_q;
    o_mov_d      = o_mov_q;
    o_pflag_d    = o_pflag_q;
    mul_a        = '0;

    dt     = t1_q - last_upd_q;
    st     = ST_OK;
    df_mag = '0;
    ev_odo = '0;
    ev_gps = '0;
    supp   = odo_susp_q;
    hit    = EV_SAFE;
    oth    = EV_OVER;
    mov    = moving_q;
    fire   = 1'b0;
    odo_p  = odo_pend_q;
    gps_p  = gps_pend_q;
    irq    = irq_q;
    rel    = release_q;
    pflag  = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OVER_SPEED: osl_d       = cfg_data_i[15:0];
        CFG_BRAKE:      brake_lim_d = cfg_data_i[23:0];
        CFG_ODO_EN:     odo_en_d    = cfg_data_i[5:0];
        CFG_GPS_EN:     gps_en_d    = cfg_data_i[1:0];
        CFG_TIMEOUT:    timeout_d   = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t1_d    = time_ms_i;
          c1_d    = pulse_count_i;
          fix_d   = gps_fix_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (dt[31:9] == 23'd0) begin
          st = ST_SOON;
        end else begin
          last_upd_d = t1_q;
          if (t1_q < prev_time_q) begin
            prev_time_d  = t1_q;
            prev_count_d = c1_q;
            st           = ST_WRAP;
          end
        end
        if (st != ST_OK) begin
          o_status_d = st;
          o_freq_d   = prev_freq_q;
          o_df_d     = '0;
          o_odo_d    = odo_pend_q;
          o_gps_d    = gps_pend_q;
          o_irq_d    = irq_q;
          o_mov_d    = moving_q;
          o_pflag_d  = |{odo_pend_q, gps_pend_q};
          state_d    = S_OUT;
        end else if (c1_q == prev_count_q) begin
          // unchanged count keeps the old interval for the brake check
          freq_d  = '0;
          state_d = S_DF;
        end else begin
          last_int_d = t1_q - prev_time_q;
          mul_a      = c1_q - prev_count_q;
          mul_d      = prod;
          state_d    = S_FLOAD;
        end
      end
      S_FLOAD: begin
        // quotient of 2^16 or more, or a zero interval, saturates
        if ({6'd0, mul_q[41:16]} >= last_int_q) begin
          freq_d  = 16'hFFFF;
          state_d = S_DF;
        end else begin
          rem_d   = {6'd0, mul_q[41:16]};
          dv_d    = {mul_q[15:0], 8'd0};
          cnt_d   = 5'd15;
          state_d = S_FDIV;
        end
      end
      S_FDIV: begin
        rem_d = step_rem;
        dv_d  = step_dv;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          freq_d  = step_dv[15:0];
          state_d = S_DF;
        end
      end
      S_DF: begin
        df_d        = $signed({1'b0, freq_q}) - $signed({1'b0, prev_freq_q});
        df_mag      = 17'(-df_d);
        brake_hit_d = 1'b0;
        if (brake_lim_q != 24'd0 && df_d[16]) begin
          mul_a   = {16'd0, df_mag[15:0]};
          mul_d   = prod;
          state_d = S_BLOAD;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_BLOAD: begin
        // rate of 2^24 or more always exceeds the 24 bit limit
        if ({30'd0, mul_q[25:24]} >= last_int_q) begin
          brake_hit_d = 1'b1;
          state_d     = S_EVAL;
        end else begin
          rem_d   = {30'd0, mul_q[25:24]};
          dv_d    = mul_q[23:0];
          cnt_d   = 5'd23;
          state_d = S_BDIV;
        end
      end
      S_BDIV: begin
        rem_d = step_rem;
        dv_d  = step_dv;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          brake_hit_d = step_dv > brake_lim_q;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (checked_q == 16'd0) begin
          if (freq_q != 16'd0) begin
            ev_odo = ev_odo | EV_MOVE;
            mov    = 1'b1;
          end
        end else if (freq_q == 16'd0) begin
          ev_odo = ev_odo | EV_STOP;
          mov    = 1'b0;
        end

        if (brake_lim_q != 24'd0) begin
          if (df_q[16]) begin
            if (brake_hit_q && (supp & EV_BRAKE) == 6'd0) begin
              ev_odo = ev_odo | EV_BRAKE;
              supp   = supp | EV_BRAKE;
            end
          end else begin
            supp = supp & ~EV_BRAKE;
          end
        end

        if (osl_q != 16'd0) begin
          if (freq_q > osl_q) begin
            hit = EV_OVER;
            oth = EV_SAFE;
          end else begin
            hit = EV_SAFE;
            oth = EV_OVER;
          end
          supp = supp & ~oth;
          if ((supp & hit) == 6'd0) begin
            ev_odo = ev_odo | hit;
            supp   = supp | hit;
          end
        end

        if (fix_q != last_fix_q) begin
          ev_gps     = (fix_q != 2'd0) ? FIX_GAIN : FIX_LOSS;
          last_fix_d = fix_q;
        end

        // only a newly pending enabled event drives the line
        fire  = (|(ev_odo & odo_en_q & ~odo_pend_q)) | (|(ev_gps & gps_en_q & ~gps_pend_q));
        odo_p = odo_pend_q | ev_odo;
        gps_p = gps_pend_q | ev_gps;
        irq   = irq_q | fire;
        rel   = (fire && timeout_q != 32'd0) ? t1_q + timeout_q : release_q;
        pflag = |{odo_p, gps_p};
        if (timeout_q != 32'd0 && rel < t1_q) begin
          odo_p = '0;
          gps_p = '0;
          irq   = 1'b0;
        end

        prev_freq_d  = freq_q;
        prev_time_d  = t1_q;
        prev_count_d = c1_q;
        checked_d    = freq_q;
        odo_susp_d   = supp;
        moving_d     = mov;
        odo_pend_d   = odo_p;
        gps_pend_d   = gps_p;
        irq_d        = irq;
        release_d    = rel;

        o_status_d = ST_OK;
        o_freq_d   = freq_q;
        o_df_d     = df_q;
        o_odo_d    = odo_p;
        o_gps_d    = gps_p;
        o_irq_d    = irq;
        o_mov_d    = mov;
        o_pflag_d  = pflag;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      osl_q        <= '0;
      brake_lim_q  <= '0;
      odo_en_q     <= ODO_EN_RST;
      gps_en_q     <= GPS_EN_RST;
      timeout_q    <= TIMEOUT_RST;
      last_upd_q   <= '0;
      prev_time_q  <= '0;
      prev_count_q <= '0;
      prev_freq_q  <= '0;
      last_int_q   <= '0;
      checked_q    <= '0;
      last_fix_q   <= '0;
      odo_susp_q   <= '0;
      odo_pend_q   <= '0;
      gps_pend_q   <= '0;
      release_q    <= '0;
      irq_q        <= 1'b0;
      moving_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      osl_q        <= osl_d;
      brake_lim_q  <= brake_lim_d;
      odo_en_q     <= odo_en_d;
      gps_en_q     <= gps_en_d;
      timeout_q    <= timeout_d;
      last_upd_q   <= last_upd_d;
      prev_time_q  <= prev_time_d;
      prev_count_q <= prev_count_d;
      prev_freq_q  <= prev_freq_d;
      last_int_q   <= last_int_d;
      checked_q    <= checked_d;
      last_fix_q   <= last_fix_d;
      odo_susp_q   <= odo_susp_d;
      odo_pend_q   <= odo_pend_d;
      gps_pend_q   <= gps_pend_d;
      release_q    <= release_d;
      irq_q        <= irq_d;
      moving_q     <= moving_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q        <= t1_d;
    c1_q        <= c1_d;
    fix_q       <= fix_d;
    mul_q       <= mul_d;
    rem_q       <= rem_d;
    dv_q        <= dv_d;
    cnt_q       <= cnt_d;
    freq_q      <= freq_d;
    df_q        <= df_d;
    brake_hit_q <= brake_hit_d;
    o_status_q  <= o_status_d;
    o_freq_q    <= o_freq_d;
    o_df_q      <= o_df_d;
    o_odo_q     <= o_odo_d;
    o_gps_q     <= o_gps_d;
    o_irq_q     <= o_irq_d;
    o_mov_q     <= o_mov_d;
    o_pflag_q   <= o_pflag_d;
  end

  assign in_stall_o         = state_q != S_IDLE;
  assign out_valid_o        = state_q == S_OUT;
  assign cfg_ready_o        = 1'b1;
  assign status_o           = o_status_q;
  assign frequency_o        = o_freq_q;
  assign frequency_change_o = o_df_q;
  assign odo_pending_mask_o = o_odo_q;
  assign gps_pending_mask_o = o_gps_q;
  assign irq_request_o      = o_irq_q;
  assign moving_flag_o      = o_mov_q;
  assign pending_flag_o     = o_pflag_q;

  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result word waits");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CHECK))
    else $error("accepted word did not enter the check step");

  a_unchecked_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (frequency_change_o == 17'sd0))
    else $error("frequency change on an unchecked poll");

  a_unchecked_pflag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK)
      |-> (pending_flag_o == (|{odo_pending_mask_o, gps_pending_mask_o})))
    else $error("pending flag does not match masks on an unchecked poll");

endmodule
